[sv/cpt_pkg.sv]
package cpt_pkg;

  localparam int PHASE_BITS  = 24;
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int ACC_BITS    = PHASE_BITS + FRAC_BITS;
  localparam int COEF_BITS   = 32;
  localparam int COEF_FRAC   = 24;
  localparam int NUM_COEF    = 5;
  localparam int TURN_BITS   = 32;
  localparam int CORDIC_N    = 30;
  localparam int ITER_W      = 5;
  localparam int VEC_W       = 44;
  localparam int WIDE_W      = 34;
  localparam int SAT_IN_W    = WIDE_W - SAMPLE_BITS + 1;
  localparam int OPND_W      = 44;
  localparam int HI_W        = OPND_W - COEF_FRAC;
  localparam int MUL_W       = 56;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int OP_W        = 3;
  localparam logic signed [WIDE_W-1:0] CORDIC_GAIN = 34'sd652032874;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_MODE,
    REG_COEF_0,
    REG_COEF_1,
    REG_COEF_2,
    REG_COEF_3,
    REG_COEF_4,
    REG_FREQ_MAX,
    REG_FREQ_MIN
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_ALPHA_BETA,
    MODE_LEAD_LAG,
    MODE_PIID
  } mode_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_i;
    logic signed [SAMPLE_BITS-1:0] sample_q;
  } sample_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] ref_cos;
    logic signed [SAMPLE_BITS-1:0] ref_sin;
    logic signed [SAMPLE_BITS-1:0] mixed_i;
    logic signed [SAMPLE_BITS-1:0] mixed_q;
    logic signed [PHASE_BITS-1:0]  phase_error;
  } result_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_i;
    logic signed [SAMPLE_BITS-1:0] sample_q;
    logic [PHASE_BITS-1:0]         angle;
  } qitem_t;

  typedef struct packed {
    logic [1:0]                          filter_mode;
    logic [NUM_COEF-1:0][COEF_BITS-1:0]  coef;
    logic signed [PHASE_BITS-1:0]        freq_max;
    logic signed [PHASE_BITS-1:0]        freq_min;
  } cfg_t;

  typedef struct packed {
    logic                        start;
    logic signed [COEF_BITS-1:0] coef;
    logic signed [OPND_W-1:0]    opnd;
  } mul_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [MUL_W-1:0] res;
  } mul_rsp_t;

  // arctangent of 2^-i in 32-bit turns
  function automatic logic [TURN_BITS-1:0] atan_step(input logic [ITER_W-1:0] idx);
    case (idx)
      5'd0:    return 32'd536870912;
      5'd1:    return 32'd316933406;
      5'd2:    return 32'd167458907;
      5'd3:    return 32'd85004756;
      5'd4:    return 32'd42667331;
      5'd5:    return 32'd21354465;
      5'd6:    return 32'd10679838;
      5'd7:    return 32'd5340245;
      5'd8:    return 32'd2670163;
      5'd9:    return 32'd1335087;
      5'd10:   return 32'd667544;
      5'd11:   return 32'd333772;
      5'd12:   return 32'd166886;
      5'd13:   return 32'd83443;
      5'd14:   return 32'd41722;
      5'd15:   return 32'd20861;
      5'd16:   return 32'd10430;
      5'd17:   return 32'd5215;
      5'd18:   return 32'd2608;
      5'd19:   return 32'd1304;
      5'd20:   return 32'd652;
      5'd21:   return 32'd326;
      5'd22:   return 32'd163;
      5'd23:   return 32'd81;
      5'd24:   return 32'd41;
      5'd25:   return 32'd20;
      5'd26:   return 32'd10;
      5'd27:   return 32'd5;
      5'd28:   return 32'd3;
      5'd29:   return 32'd1;
      default: return 32'd0;
    endcase
  endfunction

  function automatic logic signed [ACC_BITS-1:0] sat_acc(input logic signed [MUL_W-1:0] v);
    logic signed [MUL_W-1:0] hi;
    logic signed [MUL_W-1:0] lo;
    hi = {{(MUL_W-ACC_BITS+1){1'b0}}, {(ACC_BITS-1){1'b1}}};
    lo = ~hi;
    if (v > hi) return hi[ACC_BITS-1:0];
    else if (v < lo) return lo[ACC_BITS-1:0];
    else return v[ACC_BITS-1:0];
  endfunction

  function automatic logic signed [PHASE_BITS-1:0] sat_freq(input logic signed [MUL_W:0] v);
    logic signed [MUL_W:0] hi;
    logic signed [MUL_W:0] lo;
    hi = {{(MUL_W-PHASE_BITS+2){1'b0}}, {(PHASE_BITS-1){1'b1}}};
    lo = ~hi;
    if (v > hi) return hi[PHASE_BITS-1:0];
    else if (v < lo) return lo[PHASE_BITS-1:0];
    else return v[PHASE_BITS-1:0];
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(
    input logic signed [SAT_IN_W-1:0] v
  );
    logic signed [SAT_IN_W-1:0] hi;
    logic signed [SAT_IN_W-1:0] lo;
    hi = {{(SAT_IN_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    lo = ~hi;
    if (v > hi) return hi[SAMPLE_BITS-1:0];
    else if (v < lo) return lo[SAMPLE_BITS-1:0];
    else return v[SAMPLE_BITS-1:0];
  endfunction

endpackage

[sv/carrier_phase_tracking_pll_unit.sv]
// Carrier phase tracking loop. Each sample word gives one result word: cos and sin of the
// phase held before the word, the sample rotated by minus that phase, and the wrapped phase
// error; in the three filter modes the loop filter then advances the phase. A front section
// runs a 30-step atan2 CORDIC and hands the sample and its angle to a four-word queue; the
// back section takes a word, runs a 30-step sin/cos CORDIC, four mixing multiplies, then the
// loop filter through one shared 32-bit multiplier; the back section sets the sustained
// rate. Configuration writes are accepted every cycle, and every write clears the filter
// histories. Writes belong to idle periods: the user must keep to this, as the block
// itself does not enforce it.
module carrier_phase_tracking_pll_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 sample_valid,
  output logic                                 sample_stall,
  input  cpt_pkg::sample_t                     sample,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output cpt_pkg::result_t                     result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [cpt_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [cpt_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int PB = cpt_pkg::PHASE_BITS;

  cpt_pkg::cfg_t     cfg;
  cpt_pkg::qitem_t   push_item;
  cpt_pkg::qitem_t   pop_item;
  cpt_pkg::mul_req_t mul_req;
  cpt_pkg::mul_rsp_t mul_rsp;
  logic push;
  logic pop;
  logic full;
  logic empty;
  logic hist_clr;

  assign cfg_ready = 1'b1;
  assign hist_clr  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_mode <= '0;
      cfg.coef        <= '0;
      cfg.freq_max    <= {1'b0, {(PB-1){1'b1}}};
      cfg.freq_min    <= {1'b1, {(PB-1){1'b0}}};
    end else if (cfg_valid && cfg_ready) begin
      case (cpt_pkg::reg_idx_t'(cfg_index))
        cpt_pkg::REG_FILTER_MODE: cfg.filter_mode <= cfg_data[1:0];
        cpt_pkg::REG_COEF_0:      cfg.coef[0] <= cfg_data;
        cpt_pkg::REG_COEF_1:      cfg.coef[1] <= cfg_data;
        cpt_pkg::REG_COEF_2:      cfg.coef[2] <= cfg_data;
        cpt_pkg::REG_COEF_3:      cfg.coef[3] <= cfg_data;
        cpt_pkg::REG_COEF_4:      cfg.coef[4] <= cfg_data;
        cpt_pkg::REG_FREQ_MAX:    cfg.freq_max <= cfg_data[PB-1:0];
        cpt_pkg::REG_FREQ_MIN:    cfg.freq_min <= cfg_data[PB-1:0];
        default: ;
      endcase
    end
  end

  cpt_front u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .queue_full   (full),
    .queue_push   (push),
    .queue_item   (push_item)
  );

  cpt_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (empty)
  );

  cpt_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  cpt_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .hist_clr     (hist_clr),
    .queue_empty  (empty),
    .queue_pop    (pop),
    .queue_item   (pop_item),
    .mul_req      (mul_req),
    .mul_rsp      (mul_rsp),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

[sv/cpt_fifo.sv]
module cpt_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  cpt_pkg::qitem_t push_item,
  output logic            full,
  input  logic            pop,
  output cpt_pkg::qitem_t pop_item,
  output logic            empty
);

  cpt_pkg::qitem_t mem [cpt_pkg::QUEUE_DEPTH];
  logic [cpt_pkg::QPTR_W-1:0] wr_ptr;
  logic [cpt_pkg::QPTR_W-1:0] rd_ptr;
  logic [cpt_pkg::QCNT_W-1:0] count;

  assign full     = (count == cpt_pkg::QCNT_W'(cpt_pkg::QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= cpt_pkg::QCNT_W'(cpt_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow a push");

endmodule

[sv/cpt_front.sv]
module cpt_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  cpt_pkg::sample_t sample,
  input  logic             queue_full,
  output logic             queue_push,
  output cpt_pkg::qitem_t  queue_item
);

  typedef enum logic [1:0] {F_IDLE, F_RUN, F_PUSH} state_t;

  localparam int VW = cpt_pkg::VEC_W;
  localparam int SB = cpt_pkg::SAMPLE_BITS;
  localparam int SCALE = 40 - SB;
  localparam int TB = cpt_pkg::TURN_BITS;
  localparam int PB = cpt_pkg::PHASE_BITS;

  state_t state;
  logic signed [VW-1:0] x;
  logic signed [VW-1:0] y;
  logic [TB-1:0] z;
  logic [cpt_pkg::ITER_W-1:0] iter;
  logic zero_in;
  logic signed [SB-1:0] si;
  logic signed [SB-1:0] sq;

  logic signed [VW-1:0] xs;
  logic signed [VW-1:0] ys;
  logic signed [VW-1:0] xi;
  logic signed [VW-1:0] yi;
  logic [TB-1:0] tab;
  logic [TB-1:0] z_rnd;

  assign xs  = x >>> iter;
  assign ys  = y >>> iter;
  assign tab = cpt_pkg::atan_step(iter);
  assign xi  = {{(VW-SB-SCALE){sample.sample_i[SB-1]}}, sample.sample_i, {SCALE{1'b0}}};
  assign yi  = {{(VW-SB-SCALE){sample.sample_q[SB-1]}}, sample.sample_q, {SCALE{1'b0}}};
  assign z_rnd = z + (TB'(1) << (TB - PB - 1));

  assign sample_stall = (state != F_IDLE);
  assign queue_push   = (state == F_PUSH) && !queue_full;

  always_comb begin
    queue_item.sample_i = si;
    queue_item.sample_q = sq;
    queue_item.angle    = zero_in ? '0 : z_rnd[TB-1 -: PB];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (sample_valid) begin
            si      <= sample.sample_i;
            sq      <= sample.sample_q;
            zero_in <= (sample.sample_i == '0) && (sample.sample_q == '0);
            iter    <= '0;
            // fold the left half plane onto the right one
            if (sample.sample_i[SB-1]) begin
              x <= -xi;
              y <= -yi;
              z <= TB'(1) << (TB - 1);
            end else begin
              x <= xi;
              y <= yi;
              z <= '0;
            end
            state <= F_RUN;
          end
        end
        F_RUN: begin
          if (!y[VW-1]) begin
            x <= x + ys;
            y <= y - xs;
            z <= z + tab;
          end else begin
            x <= x - ys;
            y <= y + xs;
            z <= z - tab;
          end
          iter <= iter + 1'b1;
          if (iter == cpt_pkg::ITER_W'(cpt_pkg::CORDIC_N - 1)) state <= F_PUSH;
        end
        F_PUSH: begin
          if (!queue_full) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

[sv/cpt_mul.sv]
module cpt_mul (
  input  logic              clk,
  input  logic              rst,
  input  cpt_pkg::mul_req_t req,
  output cpt_pkg::mul_rsp_t rsp
);

  typedef enum logic [1:0] {M_IDLE, M_LO, M_HI, M_SUM} state_t;

  localparam int CB = cpt_pkg::COEF_BITS;
  localparam int CF = cpt_pkg::COEF_FRAC;
  localparam int HW = cpt_pkg::HI_W;
  localparam int LW = CB + CF + 1;
  localparam int PW = CB + HW;
  localparam int MW = cpt_pkg::MUL_W;

  state_t state;
  logic signed [CB-1:0] c_r;
  logic signed [HW-1:0] v_hi;
  logic [CF-1:0]        v_lo;
  logic signed [LW-1:0] p_lo;
  logic signed [PW-1:0] p_hi;
  logic signed [CF:0]   v_lo_s;
  logic signed [LW-1:0] p_lo_rnd;

  assign v_lo_s   = {1'b0, v_lo};
  assign p_lo_rnd = p_lo + (LW'(1) << (CF - 1));

  // c*v/2^24 rounded, taken as hi*c + round(lo*c/2^24)
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= M_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= (state == M_SUM);
      case (state)
        M_IDLE: begin
          if (req.start) begin
            c_r   <= req.coef;
            v_hi  <= req.opnd[cpt_pkg::OPND_W-1:CF];
            v_lo  <= req.opnd[CF-1:0];
            state <= M_LO;
          end
        end
        M_LO: begin
          p_lo  <= v_lo_s * c_r;
          state <= M_HI;
        end
        M_HI: begin
          p_hi  <= v_hi * c_r;
          state <= M_SUM;
        end
        M_SUM: begin
          rsp.res  <= {{(MW-PW){p_hi[PW-1]}}, p_hi}
                    + {{(MW-LW+CF){p_lo_rnd[LW-1]}}, p_lo_rnd[LW-1:CF]};
          state    <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

  a_done_after_sum: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> $past(state) == M_SUM)
    else $error("product done without a sum step");

  a_start_when_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> state == M_IDLE)
    else $error("multiply started while busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    rsp.done |=> !rsp.done)
    else $error("done held longer than one cycle");

endmodule

[sv/cpt_back.sv]
module cpt_back (
  input  logic              clk,
  input  logic              rst,
  input  cpt_pkg::cfg_t     cfg,
  input  logic              hist_clr,
  input  logic              queue_empty,
  output logic              queue_pop,
  input  cpt_pkg::qitem_t   queue_item,
  output cpt_pkg::mul_req_t mul_req,
  input  cpt_pkg::mul_rsp_t mul_rsp,
  output logic              result_valid,
  input  logic              result_stall,
  output cpt_pkg::result_t  result
);

  typedef enum logic [2:0] {
    B_IDLE, B_ROT, B_TRIG, B_MIX, B_OP, B_WAIT, B_FIN, B_OUT
  } state_t;

  localparam int PB = cpt_pkg::PHASE_BITS;
  localparam int SB = cpt_pkg::SAMPLE_BITS;
  localparam int AB = cpt_pkg::ACC_BITS;
  localparam int FB = cpt_pkg::FRAC_BITS;
  localparam int WW = cpt_pkg::WIDE_W;
  localparam int OW = cpt_pkg::OPND_W;
  localparam int MW = cpt_pkg::MUL_W;
  localparam int TB = cpt_pkg::TURN_BITS;
  localparam int ESW = PB + 3;

  state_t state;
  cpt_pkg::mode_t mode;

  logic [PB-1:0]        phase_acc;
  logic signed [PB-1:0] freq_acc;
  logic signed [PB-1:0] err_hist_1;
  logic signed [PB-1:0] err_hist_2;
  logic signed [AB-1:0] filt_hist_1;
  logic signed [AB-1:0] filt_hist_2;
  logic signed [AB-1:0] integ_prev;
  logic signed [AB-1:0] dint_prev_1;
  logic signed [AB-1:0] dint_prev_2;
  logic signed [AB-1:0] deriv_prev;

  logic signed [PB-1:0] err;
  logic signed [SB-1:0] si;
  logic signed [SB-1:0] sq;
  logic signed [WW-1:0] rx;
  logic signed [WW-1:0] ry;
  logic signed [TB-1:0] rz;
  logic                 flip;
  logic [cpt_pkg::ITER_W-1:0] iter;
  logic signed [SB-1:0] cs;
  logic signed [SB-1:0] sn;
  logic signed [WW-1:0] mix_i;
  logic signed [WW-1:0] mix_q;
  logic [cpt_pkg::OP_W-1:0] k;
  logic signed [MW-1:0] acc;
  logic signed [AB-1:0] f_i;
  logic signed [AB-1:0] f_ii;
  logic signed [AB-1:0] f_d;

  logic [TB-1:0]        a_turn;
  logic signed [WW-1:0] rxs;
  logic signed [WW-1:0] rys;
  logic [TB-1:0]        tab;
  logic signed [WW-1:0] fx;
  logic signed [WW-1:0] fy;
  logic signed [WW-1:0] fx_rnd;
  logic signed [WW-1:0] fy_rnd;
  logic signed [SB-1:0] m_a;
  logic signed [SB-1:0] m_b;
  logic signed [2*SB-1:0] m_prod;
  logic signed [WW-1:0] m_p;
  logic signed [WW-1:0] mi_rnd;
  logic signed [WW-1:0] mq_rnd;
  logic [cpt_pkg::OP_W-1:0] nops;
  logic [2:0]               coef_idx;
  logic signed [OW-1:0] o_e;
  logic signed [OW-1:0] o_e1;
  logic signed [OW-1:0] o_e2;
  logic signed [OW-1:0] o_eint;
  logic signed [OW-1:0] o_integ;
  logic signed [OW-1:0] o_d1;
  logic signed [OW-1:0] o_d2;
  logic signed [OW-1:0] o_deriv;
  logic signed [OW-1:0] o_fh1;
  logic signed [OW-1:0] o_fh2;
  logic signed [ESW-1:0] e_sum;
  logic signed [MW-1:0]  r;
  logic signed [MW:0]    f_sum;
  logic signed [AB-1:0]  f_sat;
  logic signed [AB-1:0]  r_sat;
  logic signed [AB:0]    f_rnd;
  logic [PB-1:0]         step;

  assign mode   = cpt_pkg::mode_t'(cfg.filter_mode);
  assign a_turn = {phase_acc, {(TB-PB){1'b0}}};
  assign rxs    = rx >>> iter;
  assign rys    = ry >>> iter;
  assign tab    = cpt_pkg::atan_step(iter);
  assign fx     = flip ? -rx : rx;
  assign fy     = flip ? -ry : ry;
  assign fx_rnd = fx + (WW'(1) << (SB - 2));
  assign fy_rnd = fy + (WW'(1) << (SB - 2));
  assign mi_rnd = mix_i + (WW'(1) << (SB - 2));
  assign mq_rnd = mix_q + (WW'(1) << (SB - 2));
  assign m_a    = (k == 3'd0 || k == 3'd3) ? si : sq;
  assign m_b    = (k == 3'd0 || k == 3'd2) ? cs : sn;
  assign m_prod = m_a * m_b;
  assign m_p    = {{(WW-2*SB){m_prod[2*SB-1]}}, m_prod};

  assign queue_pop = (state == B_IDLE) && !queue_empty;

  // operands in angle units with 16 fraction bits; o_eint carries err with none
  assign o_e     = {{(OW-AB){err[PB-1]}}, err, {FB{1'b0}}};
  assign o_e1    = {{(OW-AB){err_hist_1[PB-1]}}, err_hist_1, {FB{1'b0}}};
  assign o_e2    = {{(OW-AB){err_hist_2[PB-1]}}, err_hist_2, {FB{1'b0}}};
  assign o_eint  = {{(OW-PB){err[PB-1]}}, err};
  assign o_integ = {{(OW-AB){integ_prev[AB-1]}}, integ_prev};
  assign o_d1    = {{(OW-AB){dint_prev_1[AB-1]}}, dint_prev_1};
  assign o_d2    = {{(OW-AB){dint_prev_2[AB-1]}}, dint_prev_2};
  assign o_deriv = {{(OW-AB){deriv_prev[AB-1]}}, deriv_prev};
  assign o_fh1   = {{(OW-AB){filt_hist_1[AB-1]}}, filt_hist_1};
  assign o_fh2   = {{(OW-AB){filt_hist_2[AB-1]}}, filt_hist_2};
  assign e_sum   = {{3{err[PB-1]}}, err} + {{2{err_hist_1[PB-1]}}, err_hist_1, 1'b0}
                 + {{3{err_hist_2[PB-1]}}, err_hist_2};

  assign r      = mul_rsp.res;
  assign r_sat  = cpt_pkg::sat_acc(r);
  assign f_sum  = {r[MW-1], r} + {{(MW-PB+1){freq_acc[PB-1]}}, freq_acc};
  assign f_sat  = cpt_pkg::sat_acc(acc);
  assign f_rnd  = {f_sat[AB-1], f_sat} + ((AB+1)'(1) << (FB - 1));
  assign step   = f_rnd[AB-1:FB];

  always_comb begin
    case (mode)
      cpt_pkg::MODE_ALPHA_BETA: nops = 3'd2;
      cpt_pkg::MODE_LEAD_LAG:   nops = 3'd5;
      cpt_pkg::MODE_PIID:       nops = 3'd4;
      default:                  nops = 3'd0;
    endcase
  end

  always_comb begin
    coef_idx     = 3'd0;
    mul_req.opnd = o_e;
    case (mode)
      cpt_pkg::MODE_ALPHA_BETA: begin
        coef_idx     = (k == 3'd0) ? 3'd1 : 3'd0;
        mul_req.opnd = o_eint;
      end
      cpt_pkg::MODE_LEAD_LAG: begin
        case (k)
          3'd0: begin coef_idx = 3'd0; mul_req.opnd = o_e;   end
          3'd1: begin coef_idx = 3'd1; mul_req.opnd = o_e1;  end
          3'd2: begin coef_idx = 3'd2; mul_req.opnd = o_e2;  end
          3'd3: begin coef_idx = 3'd3; mul_req.opnd = o_fh1; end
          default: begin coef_idx = 3'd4; mul_req.opnd = o_fh2; end
        endcase
      end
      cpt_pkg::MODE_PIID: begin
        case (k)
          3'd0: begin coef_idx = 3'd1; mul_req.opnd = o_e + o_e1 + o_integ; end
          3'd1: begin
            coef_idx     = 3'd2;
            mul_req.opnd = {e_sum[ESW-1], e_sum, {FB{1'b0}}} + (o_d1 <<< 1) - o_d2;
          end
          3'd2: begin coef_idx = 3'd3; mul_req.opnd = o_e - o_e1 - o_deriv; end
          default: begin coef_idx = 3'd0; mul_req.opnd = o_e; end
        endcase
      end
      default: ;
    endcase
    mul_req.coef  = cfg.coef[coef_idx];
    mul_req.start = (state == B_OP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      result_valid <= 1'b0;
      phase_acc    <= '0;
      freq_acc     <= '0;
      err_hist_1   <= '0;
      err_hist_2   <= '0;
      filt_hist_1  <= '0;
      filt_hist_2  <= '0;
      integ_prev   <= '0;
      dint_prev_1  <= '0;
      dint_prev_2  <= '0;
      deriv_prev   <= '0;
    end else begin
      if (result_valid && !result_stall && state != B_OUT) result_valid <= 1'b0;
      case (state)
        B_IDLE: begin
          if (!queue_empty) begin
            si   <= queue_item.sample_i;
            sq   <= queue_item.sample_q;
            err  <= queue_item.angle - phase_acc;
            // rotate by a half turn when the angle lies in the left half plane
            flip <= a_turn[TB-1] ^ a_turn[TB-2];
            rz   <= {a_turn[TB-2], a_turn[TB-2:0]};
            rx   <= cpt_pkg::CORDIC_GAIN;
            ry   <= '0;
            iter <= '0;
            state <= B_ROT;
          end
        end
        B_ROT: begin
          if (!rz[TB-1]) begin
            rx <= rx - rys;
            ry <= ry + rxs;
            rz <= rz - $signed(tab);
          end else begin
            rx <= rx + rys;
            ry <= ry - rxs;
            rz <= rz + $signed(tab);
          end
          iter <= iter + 1'b1;
          if (iter == cpt_pkg::ITER_W'(cpt_pkg::CORDIC_N - 1)) state <= B_TRIG;
        end
        B_TRIG: begin
          cs    <= cpt_pkg::sat_smp(fx_rnd[WW-1:SB-1]);
          sn    <= cpt_pkg::sat_smp(fy_rnd[WW-1:SB-1]);
          k     <= '0;
          state <= B_MIX;
        end
        B_MIX: begin
          case (k)
            3'd0:    mix_i <= m_p;
            3'd1:    mix_i <= mix_i + m_p;
            3'd2:    mix_q <= m_p;
            default: mix_q <= mix_q - m_p;
          endcase
          if (k == 3'd3) begin
            k     <= '0;
            state <= (nops == '0) ? B_FIN : B_OP;
          end else begin
            k <= k + 1'b1;
          end
        end
        B_OP: begin
          state <= B_WAIT;
        end
        B_WAIT: begin
          if (mul_rsp.done) begin
            case (mode)
              cpt_pkg::MODE_ALPHA_BETA: begin
                if (k == 3'd0) freq_acc <= cpt_pkg::sat_freq(f_sum);
                else acc <= r;
              end
              cpt_pkg::MODE_LEAD_LAG: begin
                case (k)
                  3'd0:       acc <= r;
                  3'd1, 3'd2: acc <= acc + r;
                  default:    acc <= acc - r;
                endcase
              end
              cpt_pkg::MODE_PIID: begin
                case (k)
                  3'd0: begin f_i  <= r_sat; acc <= {{(MW-AB){r_sat[AB-1]}}, r_sat}; end
                  3'd1: begin f_ii <= r_sat; acc <= acc + {{(MW-AB){r_sat[AB-1]}}, r_sat}; end
                  3'd2: begin f_d  <= r_sat; acc <= acc + {{(MW-AB){r_sat[AB-1]}}, r_sat}; end
                  default: acc <= acc + r;
                endcase
              end
              default: ;
            endcase
            if (k == nops - 1'b1) begin
              k     <= '0;
              state <= B_FIN;
            end else begin
              k     <= k + 1'b1;
              state <= B_OP;
            end
          end
        end
        B_FIN: begin
          case (mode)
            cpt_pkg::MODE_ALPHA_BETA: begin
              phase_acc <= phase_acc + freq_acc + acc[PB-1:0];
            end
            cpt_pkg::MODE_LEAD_LAG: begin
              phase_acc   <= phase_acc + step;
              filt_hist_2 <= filt_hist_1;
              filt_hist_1 <= f_sat;
              err_hist_2  <= err_hist_1;
              err_hist_1  <= err;
            end
            cpt_pkg::MODE_PIID: begin
              phase_acc   <= phase_acc + step;
              err_hist_2  <= err_hist_1;
              err_hist_1  <= err;
              integ_prev  <= f_i;
              dint_prev_2 <= dint_prev_1;
              dint_prev_1 <= f_ii;
              deriv_prev  <= f_d;
            end
            default: ;
          endcase
          // upper bound is tested first: when the bounds cross, it wins for values above it
          if (freq_acc > cfg.freq_max) freq_acc <= cfg.freq_max;
          else if (freq_acc < cfg.freq_min) freq_acc <= cfg.freq_min;
          state <= B_OUT;
        end
        B_OUT: begin
          if (!result_valid || !result_stall) begin
            result.ref_cos     <= cs;
            result.ref_sin     <= sn;
            result.mixed_i     <= cpt_pkg::sat_smp(mi_rnd[WW-1:SB-1]);
            result.mixed_q     <= cpt_pkg::sat_smp(mq_rnd[WW-1:SB-1]);
            result.phase_error <= err;
            result_valid       <= 1'b1;
            state              <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
      if (hist_clr) begin
        err_hist_1  <= '0;
        err_hist_2  <= '0;
        filt_hist_1 <= '0;
        filt_hist_2 <= '0;
        integ_prev  <= '0;
        dint_prev_1 <= '0;
        dint_prev_2 <= '0;
        deriv_prev  <= '0;
      end
    end
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mul_rsp.done |-> state == B_WAIT)
    else $error("product arrived outside the wait step");

  a_pop_starts_rot: assert property (@(posedge clk) disable iff (rst)
    queue_pop |=> state == B_ROT)
    else $error("popped word did not start the rotation");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == B_OUT)
    else $error("result word loaded outside the output step");

endmodule

[verif/cpt_loop_checker.sv]
module cpt_loop_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  input  logic              sample_stall,
  input  cpt_pkg::sample_t  sample,
  input  logic              result_valid,
  input  logic              result_stall,
  input  cpt_pkg::result_t  result,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  output int                errors,
  output int                pending
);

  localparam int PB = cpt_pkg::PHASE_BITS;
  localparam int SB = cpt_pkg::SAMPLE_BITS;
  localparam int CF = cpt_pkg::COEF_FRAC;
  localparam int FB = cpt_pkg::FRAC_BITS;
  localparam int AB = cpt_pkg::ACC_BITS;
  localparam int NC = cpt_pkg::NUM_COEF;
  localparam int CN = cpt_pkg::CORDIC_N;
  localparam longint GAIN = 652032874;
  localparam longint PMASK = (64'sd1 <<< PB) - 1;
  localparam longint TURN_MASK = 64'hFFFF_FFFF;
  localparam longint HALF_TURN = 64'h8000_0000;
  localparam longint ANGLES [CN] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1};

  logic [1:0] loop_mode;
  longint gain [NC];
  longint fmax, fmin;
  longint phase, freq;
  longint err1, err2, filt1, filt2, integ, dint1, dint2, deriv;
  cpt_pkg::result_t expected_results [$];

  function automatic longint clip(longint v, int bits);
    longint hi;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
  endfunction

  function automatic longint sext(longint v, int w);
    v = v & ((64'sd1 <<< w) - 1);
    return v[w-1] ? v - (64'sd1 <<< w) : v;
  endfunction

  // coefficient times a 16-fraction-bit accumulator value, rounded
  function automatic longint coef_mul(longint c, longint v);
    longint vh, vl;
    vh = v >>> CF;
    vl = v - (vh <<< CF);
    return vh * c + ((vl * c + (64'sd1 <<< (CF - 1))) >>> CF);
  endfunction

  function automatic longint coef_mul_angle(longint c, longint e);
    return (c * e + (64'sd1 <<< (CF - 1))) >>> CF;
  endfunction

  function automatic longint acc_step(longint f);
    return (f + (64'sd1 <<< (FB - 1))) >>> FB;
  endfunction

  task automatic rotate_ref(input longint a, output longint c, output longint s);
    longint x, y, z, xn;
    int sh;
    bit flip;
    sh = 31 - SB;
    flip = ((a + 64'h4000_0000) & TURN_MASK) >= HALF_TURN;
    if (flip) a = (a + HALF_TURN) & TURN_MASK;
    z = a >= HALF_TURN ? a - 64'sh1_0000_0000 : a;
    x = GAIN;
    y = 0;
    for (int i = 0; i < CN; i++) begin
      if (z >= 0) begin
        xn = x - (y >>> i); y = y + (x >>> i); z -= ANGLES[i];
      end else begin
        xn = x + (y >>> i); y = y - (x >>> i); z += ANGLES[i];
      end
      x = xn;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = clip((x + (64'sd1 <<< (sh - 1))) >>> sh, SB);
    s = clip((y + (64'sd1 <<< (sh - 1))) >>> sh, SB);
  endtask

  function automatic longint sample_angle(longint si, longint sq);
    longint x, y, z, xn;
    if (si == 0 && sq == 0) return 0;
    x = si <<< (40 - SB);
    y = sq <<< (40 - SB);
    z = 0;
    if (x < 0) begin
      x = -x; y = -y; z = HALF_TURN;
    end
    for (int i = 0; i < CN; i++) begin
      if (y >= 0) begin
        xn = x + (y >>> i); y = y - (x >>> i); z += ANGLES[i];
      end else begin
        xn = x - (y >>> i); y = y + (x >>> i); z -= ANGLES[i];
      end
      x = xn;
    end
    return z & TURN_MASK;
  endfunction

  task automatic clear_history();
    err1 = 0; err2 = 0; filt1 = 0; filt2 = 0;
    integ = 0; dint1 = 0; dint2 = 0; deriv = 0;
  endtask

  task automatic track_sample(input cpt_pkg::sample_t w);
    longint si, sq, c, s, e, eu, samp, step, f, fi, fii, fd, ee, e1, e2, one;
    cpt_pkg::result_t r;
    one = 64'sd1 <<< FB;
    si = longint'(w.sample_i);
    sq = longint'(w.sample_q);
    rotate_ref((phase <<< (32 - PB)) & TURN_MASK, c, s);
    r.ref_cos = c[SB-1:0];
    r.ref_sin = s[SB-1:0];
    f = clip((si * c + sq * s + (64'sd1 <<< (SB - 2))) >>> (SB - 1), SB);
    r.mixed_i = f[SB-1:0];
    f = clip((sq * c - si * s + (64'sd1 <<< (SB - 2))) >>> (SB - 1), SB);
    r.mixed_q = f[SB-1:0];
    samp = ((sample_angle(si, sq) + (64'sd1 <<< (31 - PB))) >>> (32 - PB)) & PMASK;
    eu = (samp - phase) & PMASK;
    r.phase_error = eu[PB-1:0];
    e = sext(eu, PB);
    ee = e * one;
    e1 = err1 * one;
    e2 = err2 * one;
    step = 0;
    if (loop_mode == cpt_pkg::MODE_ALPHA_BETA) begin
      freq = clip(freq + coef_mul_angle(gain[1], e), PB);
      step = freq + coef_mul_angle(gain[0], e);
    end else if (loop_mode == cpt_pkg::MODE_LEAD_LAG) begin
      f = coef_mul(gain[0], ee) + coef_mul(gain[1], e1) + coef_mul(gain[2], e2)
          - coef_mul(gain[3], filt1) - coef_mul(gain[4], filt2);
      f = clip(f, AB);
      step = acc_step(f);
      filt2 = filt1; filt1 = f;
      err2 = err1; err1 = e;
    end else if (loop_mode == cpt_pkg::MODE_PIID) begin
      fi = clip(coef_mul(gain[1], ee + e1 + integ), AB);
      fii = clip(coef_mul(gain[2], ee + 2 * e1 + e2 + 2 * dint1 - dint2), AB);
      fd = clip(coef_mul(gain[3], ee - e1 - deriv), AB);
      f = clip(coef_mul(gain[0], ee) + fi + fii + fd, AB);
      step = acc_step(f);
      err2 = err1; err1 = e;
      integ = fi;
      dint2 = dint1; dint1 = fii;
      deriv = fd;
    end
    phase = (phase + step) & PMASK;
    if (freq > fmax) freq = fmax;
    else if (freq < fmin) freq = fmin;
    expected_results.push_back(r);
  endtask

  task automatic check_result(input cpt_pkg::result_t got);
    cpt_pkg::result_t want;
    if (expected_results.size() == 0) begin
      $error("result word with nothing expected");
      errors++;
      return;
    end
    want = expected_results.pop_front();
    if (got.ref_cos !== want.ref_cos) begin
      $error("ref_cos expected %0d got %0d", want.ref_cos, got.ref_cos); errors++;
    end
    if (got.ref_sin !== want.ref_sin) begin
      $error("ref_sin expected %0d got %0d", want.ref_sin, got.ref_sin); errors++;
    end
    if (got.mixed_i !== want.mixed_i) begin
      $error("mixed_i expected %0d got %0d", want.mixed_i, got.mixed_i); errors++;
    end
    if (got.mixed_q !== want.mixed_q) begin
      $error("mixed_q expected %0d got %0d", want.mixed_q, got.mixed_q); errors++;
    end
    if (got.phase_error !== want.phase_error) begin
      $error("phase_error expected %0d got %0d", want.phase_error, got.phase_error);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      loop_mode = cpt_pkg::MODE_ALPHA_BETA;
      for (int k = 0; k < NC; k++) gain[k] = 0;
      fmax = (64'sd1 <<< (PB - 1)) - 1;
      fmin = -fmax - 1;
      phase = 0;
      freq = 0;
      clear_history();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cpt_pkg::reg_idx_t'(cfg_index))
          cpt_pkg::REG_FILTER_MODE: loop_mode = cfg_data[1:0];
          cpt_pkg::REG_FREQ_MAX:    fmax = sext(longint'(cfg_data), PB);
          cpt_pkg::REG_FREQ_MIN:    fmin = sext(longint'(cfg_data), PB);
          default: gain[cfg_index - 1] = sext(longint'(cfg_data), cpt_pkg::COEF_BITS);
        endcase
        clear_history();
      end
      if (sample_valid && !sample_stall) track_sample(sample);
      if (result_valid && !result_stall) check_result(result);
    end
    pending = expected_results.size();
  end

endmodule

[verif/tb_carrier_phase_tracking_pll_unit.sv]
module tb_carrier_phase_tracking_pll_unit;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 120;
  localparam longint Q_ONE = 64'sd1 <<< cpt_pkg::COEF_FRAC;

  logic clk, rst;
  logic sample_valid, sample_stall;
  cpt_pkg::sample_t sample;
  logic result_valid, result_stall;
  cpt_pkg::result_t result;
  logic cfg_valid, cfg_ready;
  logic [cpt_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [cpt_pkg::CFG_DATA_W-1:0] cfg_data;
  int errors, pending, quiet_cycles;
  bit calm;

  carrier_phase_tracking_pll_unit uut (
    .clk, .rst, .sample_valid, .sample_stall, .sample, .result_valid, .result_stall,
    .result, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  cpt_loop_checker chk (
    .clk, .rst, .sample_valid, .sample_stall, .sample, .result_valid, .result_stall,
    .result, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .errors, .pending
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // receiver backpressure
  always @(negedge clk) result_stall <= !calm && ($urandom_range(99) < 27);

  always @(posedge clk) begin
    if ((sample_valid && !sample_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(input cpt_pkg::reg_idx_t idx, input longint value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[cpt_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_loop(input logic [1:0] mode, input longint c0, c1, c2, c3, c4,
                           input longint fmax, fmin);
    write_reg(cpt_pkg::REG_FILTER_MODE, mode);
    write_reg(cpt_pkg::REG_COEF_0, c0);
    write_reg(cpt_pkg::REG_COEF_1, c1);
    write_reg(cpt_pkg::REG_COEF_2, c2);
    write_reg(cpt_pkg::REG_COEF_3, c3);
    write_reg(cpt_pkg::REG_COEF_4, c4);
    write_reg(cpt_pkg::REG_FREQ_MAX, fmax);
    write_reg(cpt_pkg::REG_FREQ_MIN, fmin);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_word(input logic signed [15:0] i, q);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 27) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample <= '{sample_i: i, sample_q: q};
    @(posedge clk);
    while (sample_stall) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    sample_valid <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_edge();
    case ($urandom_range(4))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      3: return -16'sd1;
      default: return 16'sd1;
    endcase
  endfunction

  task automatic random_words(input int count);
    logic signed [15:0] i, q;
    int kind;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(9);
      if (kind <= 3) begin
        i = 16'($urandom); q = 16'($urandom);
      end else if (kind <= 5) begin
        i = 16'($urandom_range(127) - 64); q = 16'($urandom_range(127) - 64);
      end else if (kind == 6) begin
        i = pick_edge(); q = pick_edge();
      end else if (kind == 7) begin
        i = 0; q = 0;
      end else begin
        // mostly in-phase carrier with a small offset
        i = 16'(20000 + $urandom_range(2000)); q = 16'($urandom_range(4000) - 2000);
      end
      send_word(i, q);
    end
  endtask

  initial begin
    rst = 1'b1;
    sample_valid = 1'b0;
    sample = '0;
    result_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    calm = 0;
    quiet_cycles = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    load_loop(cpt_pkg::MODE_ALPHA_BETA, Q_ONE / 10, Q_ONE / 200, 0, 0, 0, 8388607, -8388608);
    send_word(0, 0);
    send_word(16'sh7FFF, 0);
    send_word(16'sh8000, 0);
    send_word(0, 16'sh7FFF);
    send_word(0, 16'sh8000);
    send_word(16'sh8000, 16'sh8000);
    send_word(16'sh7FFF, 16'sh7FFF);
    send_word(16'sh8000, 16'sh7FFF);
    send_word(16'sh7FFF, 16'sh8000);
    send_word(1, 0);
    send_word(-1, 0);
    send_word(0, -1);
    send_word(1, -1);
    send_word(-1, 16'sh5555);
    send_word(16'shAAAA, 16'sh5555);
    send_word(0, 0);
    drain();

    calm = 1;
    load_loop(cpt_pkg::MODE_LEAD_LAG, Q_ONE / 5, -Q_ONE * 19 / 100, 0, -Q_ONE, 0,
              8388607, -8388608);
    random_words(170);
    drain();
    calm = 0;

    load_loop(cpt_pkg::MODE_PIID, Q_ONE / 20, Q_ONE / 1000, Q_ONE / 10000, Q_ONE / 100, 0,
              8388607, -8388608);
    random_words(170);
    drain();

    load_loop(cpt_pkg::MODE_ALPHA_BETA, 32'h7FFF_FFFF, -64'sd2147483648, 32'h7FFF_FFFF,
              -64'sd2147483648, 32'h7FFF_FFFF, 1000, -1000);
    random_words(170);
    drain();

    load_loop(cpt_pkg::MODE_LEAD_LAG, $urandom, $urandom, $urandom, $urandom, $urandom,
              8388607, -8388608);
    random_words(170);
    drain();

    load_loop(cpt_pkg::MODE_PIID, 32'h7FFF_FFFF, 32'h7FFF_FFFF, -64'sd2147483648,
              32'h7FFF_FFFF, -64'sd2147483648, 8388607, -8388608);
    random_words(170);
    drain();

    load_loop(MODE_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom, 0, 0);
    random_words(150);
    drain();

    // clamp limits crossed over
    load_loop(cpt_pkg::MODE_ALPHA_BETA, Q_ONE / 4, Q_ONE / 8, 0, 0, 0, -5000, 5000);
    random_words(170);
    drain();

    load_loop(cpt_pkg::MODE_PIID, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom_range(8388607), -$urandom_range(8388608));
    random_words(200);
    drain();

    load_loop(cpt_pkg::MODE_ALPHA_BETA, $urandom, $urandom, $urandom, $urandom, $urandom,
              8388607, -8388608);
    random_words(150);
    drain();

    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

[filelist.f]
sv/cpt_pkg.sv
sv/cpt_fifo.sv
sv/cpt_front.sv
sv/cpt_mul.sv
sv/cpt_back.sv
sv/carrier_phase_tracking_pll_unit.sv
verif/cpt_loop_checker.sv
verif/tb_carrier_phase_tracking_pll_unit.sv
